// ===== rtl/core/isrt_pkg.sv =====
package isrt_pkg;

    localparam int MAX_ELEMENTS = 64;
    localparam int COUNT_W      = $clog2(MAX_ELEMENTS + 1);
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef logic signed [31:0] elem_t;

    typedef struct packed {
        elem_t value;
        logic  last_item;
        logic  keep;
    } qent_t;

    typedef enum logic {
        BK_LOAD,
        BK_DRAIN
    } back_state_t;

    function automatic logic comes_after(elem_t a, elem_t b, logic desc);
        logic r;
        if (desc)
        begin
            r = (a < b);
        end
        else
        begin
            r = (a > b);
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/isrt_ifs.sv =====
interface isrt_in_if;
    import isrt_pkg::*;
    logic  valid;
    logic  ready;
    elem_t value;
    logic  last_item;
    modport source(output valid, output value, output last_item, input ready);
    modport sink(input valid, input value, input last_item, output ready);
endinterface

interface isrt_out_if;
    import isrt_pkg::*;
    logic  valid;
    logic  ready;
    elem_t sorted_value;
    logic  last_result;
    logic  overflow;
    modport source(output valid, output sorted_value, output last_result,
                   output overflow, input ready);
    modport sink(input valid, input sorted_value, input last_result,
                 input overflow, output ready);
endinterface

interface isrt_cfg_if;
    logic valid;
    logic ready;
    logic data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/core/isrt_front.sv =====
module isrt_front (
    input  logic            clk,
    input  logic            rst_n,
    isrt_in_if.sink         in,
    output logic            q_valid,
    output isrt_pkg::qent_t q_data,
    input  logic            q_ready
);
    import isrt_pkg::*;

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               keep;
    logic               xfer;

    assign keep     = (count_reg < COUNT_W'(MAX_ELEMENTS));
    assign xfer     = in.valid && q_ready;
    assign in.ready = q_ready;
    assign q_valid  = in.valid;

    always_comb
    begin
        q_data.value     = in.value;
        q_data.last_item = in.last_item;
        q_data.keep      = keep;
    end

    always_comb
    begin
        count_next = count_reg;
        if (xfer)
        begin
            if (in.last_item)
            begin
                count_next = '0;
            end
            else if (keep)
            begin
                count_next = count_reg + COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/core/isrt_queue.sv =====
module isrt_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    input  isrt_pkg::qent_t push_data,
    output logic            push_ready,
    output logic            pop_valid,
    output isrt_pkg::qent_t pop_data,
    input  logic            pop_ready
);
    import isrt_pkg::*;

    qent_t             slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] fill_reg;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (fill_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : rd_ptr_reg + QPTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + QCNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - QCNT_W'(1);
            end
        end
    end

endmodule

// ===== rtl/core/isrt_back.sv =====
module isrt_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            descending,
    input  logic            q_valid,
    input  isrt_pkg::qent_t q_data,
    output logic            q_ready,
    isrt_out_if.source      out
);
    import isrt_pkg::*;

    back_state_t state_reg;
    back_state_t state_next;
    elem_t       elem_reg [MAX_ELEMENTS];
    elem_t       elem_next [MAX_ELEMENTS];
    logic        vld_reg [MAX_ELEMENTS];
    logic        vld_next [MAX_ELEMENTS];
    logic        after [MAX_ELEMENTS];
    logic        ovf_reg;
    logic        ovf_next;
    logic        pop;
    logic        insert;
    logic        drain;

    assign q_ready          = (state_reg == BK_LOAD);
    assign pop              = q_valid && q_ready;
    assign insert           = pop && q_data.keep;
    assign out.valid        = (state_reg == BK_DRAIN) && vld_reg[0];
    assign out.sorted_value = elem_reg[0];
    assign out.last_result  = !vld_reg[1];
    assign out.overflow     = ovf_reg;
    assign drain            = out.valid && out.ready;

    always_comb
    begin
        for (int i = 0; i < MAX_ELEMENTS; i++)
        begin
            after[i] = !vld_reg[i] || comes_after(elem_reg[i], q_data.value, descending);
        end
    end

    // Cells hold the list in sorted order; a new element lands in front of
    // the first cell that must follow it, and the cells behind move up one.
    always_comb
    begin
        for (int i = 0; i < MAX_ELEMENTS; i++)
        begin
            elem_next[i] = elem_reg[i];
            vld_next[i]  = vld_reg[i];
            if (insert && after[i])
            begin
                if (i == 0 || !after[(i == 0) ? 0 : i - 1])
                begin
                    elem_next[i] = q_data.value;
                    vld_next[i]  = 1'b1;
                end
                else
                begin
                    elem_next[i] = elem_reg[(i == 0) ? 0 : i - 1];
                    vld_next[i]  = vld_reg[(i == 0) ? 0 : i - 1];
                end
            end
            else if (drain)
            begin
                if (i == MAX_ELEMENTS - 1)
                begin
                    vld_next[i] = 1'b0;
                end
                else
                begin
                    elem_next[i] = elem_reg[(i == MAX_ELEMENTS - 1) ? i : i + 1];
                    vld_next[i]  = vld_reg[(i == MAX_ELEMENTS - 1) ? i : i + 1];
                end
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ovf_next   = ovf_reg;
        case (state_reg)
            BK_LOAD:
            begin
                if (pop)
                begin
                    if (!q_data.keep)
                    begin
                        ovf_next = 1'b1;
                    end
                    if (q_data.last_item)
                    begin
                        state_next = BK_DRAIN;
                    end
                end
            end
            BK_DRAIN:
            begin
                if (drain && out.last_result)
                begin
                    state_next = BK_LOAD;
                    ovf_next   = 1'b0;
                end
            end
            default:
            begin
                state_next = BK_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_ELEMENTS; i++)
        begin
            elem_reg[i] <= elem_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_LOAD;
            ovf_reg   <= 1'b0;
            for (int i = 0; i < MAX_ELEMENTS; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg <= state_next;
            ovf_reg   <= ovf_next;
            for (int i = 0; i < MAX_ELEMENTS; i++)
            begin
                vld_reg[i] <= vld_next[i];
            end
        end
    end

endmodule

// ===== rtl/core/insertion_sorter.sv =====
// Channel  Direction  Payload
// in       sink       value, last_item
// out      source     sorted_value, last_result, overflow
// cfg      sink       data (descending bit)
//
// Each of the first MAX_ELEMENTS elements of a list is placed into its
// sorted cell of the insertion array in the cycle it leaves the queue.
// A list drains from cell 0, one result per cycle while out.ready is high.
// A two-entry queue keeps taking input while the array drains, then stalls.
// Reset clears the control state and the cell valid bits; there is no sweep.
module insertion_sorter (
    input  logic        clk,
    input  logic        rst_n,
    isrt_in_if.sink     in,
    isrt_out_if.source  out,
    isrt_cfg_if.sink    cfg
);
    import isrt_pkg::*;

    logic  descending_reg;
    logic  fq_valid;
    qent_t fq_data;
    logic  fq_ready;
    logic  qb_valid;
    qent_t qb_data;
    logic  qb_ready;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            descending_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            descending_reg <= cfg.data;
        end
    end

    isrt_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in      (in),
        .q_valid (fq_valid),
        .q_data  (fq_data),
        .q_ready (fq_ready)
    );

    isrt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_data  (fq_data),
        .push_ready (fq_ready),
        .pop_valid  (qb_valid),
        .pop_data   (qb_data),
        .pop_ready  (qb_ready)
    );

    isrt_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .descending (descending_reg),
        .q_valid    (qb_valid),
        .q_data     (qb_data),
        .q_ready    (qb_ready),
        .out        (out)
    );

    // The final transfer of a run returns the array to loading.
    a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out.valid && out.ready && out.last_result |=> !out.valid)
        else $error("result offered after the final transfer of a run");

    // The array takes no element from the queue while results are pending.
    a_no_load_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        out.valid |-> !qb_ready)
        else $error("queue popped while the sorted run drains");

    // A closing element popped from the queue starts a run in the next cycle.
    a_close_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
        qb_valid && qb_ready && qb_data.last_item |=> out.valid)
        else $error("closing element did not start a sorted run");

endmodule
